FILE: rtl/qvr_pkg.sv
// ---------------------------------------------------------------------------
// qvr_pkg
// Shared widths, types and the Hamilton product term table for the
// quaternion vertex rotation pipeline.
// ---------------------------------------------------------------------------
package qvr_pkg;

   // Fraction bits of the rotation / inverse quaternion registers.
   localparam int QUAT_FRAC_BITS = 30;

   localparam int COMP_W   = 32;                    // vertex and register components
   localparam int PROD1_W  = 2 * COMP_W;            // rot * vertex term
   localparam int SUM1_W   = PROD1_W + 2;           // sum of four terms
   localparam int R_W      = SUM1_W - QUAT_FRAC_BITS; // intermediate rot * v
   localparam int RL_W     = R_W / 2;               // low slice of intermediate
   localparam int RH_W     = R_W - RL_W;            // high slice of intermediate
   localparam int PLO_W    = RL_W + 1 + COMP_W;     // low slice * inverse
   localparam int PHI_W    = RH_W + COMP_W;         // high slice * inverse
   localparam int PROD2_W  = R_W + COMP_W;          // full intermediate * inverse
   localparam int SUM2_W   = PROD2_W + 2;
   localparam int T_W      = SUM2_W - QUAT_FRAC_BITS; // scaled, before saturation
   localparam int CSR_IDX_W = 3;
   localparam int PIPE_DEPTH = 7;                   // register stages, request to response

   typedef logic signed [COMP_W-1:0]  comp_type;
   typedef comp_type                  quat_type [4];
   typedef logic signed [R_W-1:0]     mid_type;
   typedef mid_type                   mid_quat_type [4];
   typedef logic signed [PROD1_W-1:0] prod1_type;
   typedef logic signed [SUM1_W-1:0]  sum1_type;
   typedef logic signed [PLO_W-1:0]   plo_type;
   typedef logic signed [PHI_W-1:0]   phi_type;
   typedef logic signed [PROD2_W-1:0] prod2_type;
   typedef logic signed [SUM2_W-1:0]  sum2_type;
   typedef logic signed [T_W-1:0]     scaled_type;

   localparam comp_type QUAT_ONE = comp_type'(COMP_W'(1) << QUAT_FRAC_BITS);
   localparam comp_type COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
   localparam comp_type COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

   // Quaternion component indexes.
   localparam logic [1:0] QX = 2'd0;
   localparam logic [1:0] QY = 2'd1;
   localparam logic [1:0] QZ = 2'd2;
   localparam logic [1:0] QW = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_X = 3'd0,
      CSR_ROT_Y = 3'd1,
      CSR_ROT_Z = 3'd2,
      CSR_ROT_W = 3'd3,
      CSR_INV_X = 3'd4,
      CSR_INV_Y = 3'd5,
      CSR_INV_Z = 3'd6,
      CSR_INV_W = 3'd7
   } csr_index_type;

   // One term of a Hamilton product a*b: +/- a[a_idx] * b[b_idx].
   typedef struct packed {
      logic [1:0] a_idx;
      logic [1:0] b_idx;
      logic       neg;
   } term_sel_type;

   function automatic term_sel_type term_sel(input logic [1:0] comp,
                                             input logic [1:0] term);
      term_sel_type s;
      case ({comp, term})
         {QX, 2'd0}: s = '{QW, QX, 1'b0};
         {QX, 2'd1}: s = '{QX, QW, 1'b0};
         {QX, 2'd2}: s = '{QY, QZ, 1'b0};
         {QX, 2'd3}: s = '{QZ, QY, 1'b1};
         {QY, 2'd0}: s = '{QW, QY, 1'b0};
         {QY, 2'd1}: s = '{QY, QW, 1'b0};
         {QY, 2'd2}: s = '{QZ, QX, 1'b0};
         {QY, 2'd3}: s = '{QX, QZ, 1'b1};
         {QZ, 2'd0}: s = '{QW, QZ, 1'b0};
         {QZ, 2'd1}: s = '{QZ, QW, 1'b0};
         {QZ, 2'd2}: s = '{QX, QY, 1'b0};
         {QZ, 2'd3}: s = '{QY, QX, 1'b1};
         {QW, 2'd0}: s = '{QW, QW, 1'b0};
         {QW, 2'd1}: s = '{QX, QX, 1'b1};
         {QW, 2'd2}: s = '{QY, QY, 1'b1};
         {QW, 2'd3}: s = '{QZ, QZ, 1'b1};
         default:    s = '{QW, QW, 1'b0};
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/qvr_rot_mul.sv
// ---------------------------------------------------------------------------
// qvr_rot_mul
// First Hamilton product rot * v in three stages: products, sums,
// truncation toward zero.
// ---------------------------------------------------------------------------
module qvr_rot_mul (
   input  logic                  clock,
   input  logic                  advance,
   input  qvr_pkg::quat_type     rot_q,
   input  qvr_pkg::quat_type     vert_q,
   output qvr_pkg::mid_quat_type mid_q
);
   import qvr_pkg::*;

   prod1_type prod_in [4][4];
   prod1_type prod_ff [4][4];
   sum1_type  sum_in  [4];
   sum1_type  sum_ff  [4];
   mid_type   mid_in  [4];
   mid_type   mid_ff  [4];

   // stage 1: sixteen 32x32 products
   always_comb begin
      term_sel_type sel;
      for (int k = 0; k < 4; k++) begin
         for (int t = 0; t < 4; t++) begin
            sel = term_sel(2'(k), 2'(t));
            prod_in[k][t] = rot_q[sel.a_idx] * vert_q[sel.b_idx];
         end
      end
   end

   // stage 2: signed sum of four terms per component
   always_comb begin
      term_sel_type sel;
      sum1_type     acc;
      sum1_type     term;
      for (int k = 0; k < 4; k++) begin
         acc = '0;
         for (int t = 0; t < 4; t++) begin
            sel  = term_sel(2'(k), 2'(t));
            term = SUM1_W'(prod_ff[k][t]);
            acc  = sel.neg ? acc - term : acc + term;
         end
         sum_in[k] = acc;
      end
   end

   // stage 3: shift right toward zero (bias negatives first)
   always_comb begin
      sum1_type biased;
      for (int k = 0; k < 4; k++) begin
         biased = sum_ff[k] + {{(SUM1_W-QUAT_FRAC_BITS){1'b0}},
                               {QUAT_FRAC_BITS{sum_ff[k][SUM1_W-1]}}};
         mid_in[k] = R_W'(biased >>> QUAT_FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         mid_ff  <= mid_in;
      end
   end

   assign mid_q = mid_ff;

endmodule

FILE: rtl/qvr_inv_mul.sv
// ---------------------------------------------------------------------------
// qvr_inv_mul
// Second Hamilton product r * inv in four stages: split products, product
// merge, sums, truncation toward zero with 32-bit saturation.
// ---------------------------------------------------------------------------
module qvr_inv_mul (
   input  logic                  clock,
   input  logic                  advance,
   input  qvr_pkg::mid_quat_type mid_q,
   input  qvr_pkg::quat_type     inv_q,
   output qvr_pkg::quat_type     res_q
);
   import qvr_pkg::*;

   plo_type   lo_in   [4][4];
   plo_type   lo_ff   [4][4];
   phi_type   hi_in   [4][4];
   phi_type   hi_ff   [4][4];
   prod2_type full_in [4][4];
   prod2_type full_ff [4][4];
   sum2_type  sum_in  [4];
   sum2_type  sum_ff  [4];
   comp_type  res_in  [4];
   comp_type  res_ff  [4];

   // stage 4: intermediate split in two slices, each times inverse component
   always_comb begin
      term_sel_type sel;
      mid_type      r;
      for (int k = 0; k < 4; k++) begin
         for (int t = 0; t < 4; t++) begin
            sel = term_sel(2'(k), 2'(t));
            r   = mid_q[sel.a_idx];
            lo_in[k][t] = $signed({1'b0, r[RL_W-1:0]}) * inv_q[sel.b_idx];
            hi_in[k][t] = $signed(r[R_W-1:RL_W]) * inv_q[sel.b_idx];
         end
      end
   end

   // stage 5: merge slices
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int t = 0; t < 4; t++) begin
            full_in[k][t] = (PROD2_W'(hi_ff[k][t]) <<< RL_W) + PROD2_W'(lo_ff[k][t]);
         end
      end
   end

   // stage 6: signed sum of four terms
   always_comb begin
      term_sel_type sel;
      sum2_type     acc;
      sum2_type     term;
      for (int k = 0; k < 4; k++) begin
         acc = '0;
         for (int t = 0; t < 4; t++) begin
            sel  = term_sel(2'(k), 2'(t));
            term = SUM2_W'(full_ff[k][t]);
            acc  = sel.neg ? acc - term : acc + term;
         end
         sum_in[k] = acc;
      end
   end

   // stage 7: truncate toward zero, clamp to 32 bits
   always_comb begin
      sum2_type   biased;
      scaled_type scaled;
      for (int k = 0; k < 4; k++) begin
         biased = sum_ff[k] + {{(SUM2_W-QUAT_FRAC_BITS){1'b0}},
                               {QUAT_FRAC_BITS{sum_ff[k][SUM2_W-1]}}};
         scaled = T_W'(biased >>> QUAT_FRAC_BITS);
         if ((&scaled[T_W-1:COMP_W-1]) || !(|scaled[T_W-1:COMP_W-1])) begin
            res_in[k] = scaled[COMP_W-1:0];
         end else begin
            res_in[k] = scaled[T_W-1] ? COMP_MIN : COMP_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         full_ff <= full_in;
         sum_ff  <= sum_in;
         res_ff  <= res_in;
      end
   end

   assign res_q = res_ff;

endmodule

FILE: rtl/quaternion_vertex_rotate.sv
// ---------------------------------------------------------------------------
// quaternion_vertex_rotate
// Streams vertices through the quaternion sandwich rot * v * inv.
// ---------------------------------------------------------------------------
// Each request carries one vertex (x, y, z, w in signed Q16.16, w taken as
// the quaternion scalar) and a last flag. The block returns one response per
// request, in order: rot * v * inv with both products truncated toward zero
// and the final result saturated to signed Q16.16; last is copied through.
// The rotation and inverse quaternions are signed Q2.30 registers (reset to
// identity) written through the csr_ port, indexes 0..3 for rot x,y,z,w and
// 4..7 for inv x,y,z,w; write them only while the pipeline is empty.
// Throughput is one vertex per clock while no response is held by rsp_ready.
// Requests pass through the 7-stage multiply/sum/scale pipeline (3 stages for
// the first product, 4 for the second, whose 36x32 terms are split into two
// narrower multiplies). When a response is held by rsp_ready low the whole
// pipeline freezes and req_ready drops.
// ---------------------------------------------------------------------------
module quaternion_vertex_rotate (
   input  logic                    clock,
   input  logic                    reset,
   // vertex requests
   input  logic                    req_valid,
   output logic                    req_ready,
   input  qvr_pkg::comp_type       req_in_x,
   input  qvr_pkg::comp_type       req_in_y,
   input  qvr_pkg::comp_type       req_in_z,
   input  qvr_pkg::comp_type       req_in_w,
   input  logic                    req_in_last,
   // rotated vertices
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output qvr_pkg::comp_type       rsp_out_x,
   output qvr_pkg::comp_type       rsp_out_y,
   output qvr_pkg::comp_type       rsp_out_z,
   output qvr_pkg::comp_type       rsp_out_w,
   output logic                    rsp_out_last,
   // register writes
   input  logic                    csr_wr_en,
   input  qvr_pkg::csr_index_type  csr_index,
   input  qvr_pkg::comp_type       csr_wdata
);
   import qvr_pkg::*;

   quat_type                rot_ff;
   quat_type                inv_ff;
   quat_type                vert_q;
   mid_quat_type            mid_q;
   quat_type                res_q;
   logic [PIPE_DEPTH-1:0]   vld_ff;
   logic [PIPE_DEPTH-1:0]   last_ff;
   logic                    advance;

   // Whole pipe moves unless the response stage is full and held.
   assign advance   = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   always_comb begin
      vert_q[QX] = req_in_x;
      vert_q[QY] = req_in_y;
      vert_q[QZ] = req_in_z;
      vert_q[QW] = req_in_w;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[QX] <= '0;
         rot_ff[QY] <= '0;
         rot_ff[QZ] <= '0;
         rot_ff[QW] <= QUAT_ONE;
         inv_ff[QX] <= '0;
         inv_ff[QY] <= '0;
         inv_ff[QZ] <= '0;
         inv_ff[QW] <= QUAT_ONE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROT_X: rot_ff[QX] <= csr_wdata;
            CSR_ROT_Y: rot_ff[QY] <= csr_wdata;
            CSR_ROT_Z: rot_ff[QZ] <= csr_wdata;
            CSR_ROT_W: rot_ff[QW] <= csr_wdata;
            CSR_INV_X: inv_ff[QX] <= csr_wdata;
            CSR_INV_Y: inv_ff[QY] <= csr_wdata;
            CSR_INV_Z: inv_ff[QZ] <= csr_wdata;
            CSR_INV_W: inv_ff[QW] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Valid bits travel alongside the data stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // Last flag shift line, no reset needed.
   always_ff @(posedge clock) begin
      if (advance) begin
         last_ff <= {last_ff[PIPE_DEPTH-2:0], req_in_last};
      end
   end

   // stages 1-3: r = rot * v
   qvr_rot_mul u_rot_mul (
      .clock   (clock),
      .advance (advance),
      .rot_q   (rot_ff),
      .vert_q  (vert_q),
      .mid_q   (mid_q)
   );

   // stages 4-7: res = r * inv
   qvr_inv_mul u_inv_mul (
      .clock   (clock),
      .advance (advance),
      .mid_q   (mid_q),
      .inv_q   (inv_ff),
      .res_q   (res_q)
   );

   assign rsp_out_x    = res_q[QX];
   assign rsp_out_y    = res_q[QY];
   assign rsp_out_z    = res_q[QZ];
   assign rsp_out_w    = res_q[QW];
   assign rsp_out_last = last_ff[PIPE_DEPTH-1];

   // A stall freezes every valid bit.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   // An accepted request lands in the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted request not captured");

   // A moving item in the last compute stage becomes a response.
   a_reach_output: assert property (@(posedge clock) disable iff (reset)
      (advance && vld_ff[PIPE_DEPTH-2]) |=> rsp_valid)
      else $error("item lost before response stage");

endmodule

FILE: tb/sv/qvr_rotate_checker.sv
// ---------------------------------------------------------------------------
// qvr_rotate_checker
// Watches the request, response and register ports of the quaternion vertex
// rotation block, predicts every rotated vertex and compares responses.
// ---------------------------------------------------------------------------
module qvr_rotate_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  qvr_pkg::comp_type      req_in_x,
   input  qvr_pkg::comp_type      req_in_y,
   input  qvr_pkg::comp_type      req_in_z,
   input  qvr_pkg::comp_type      req_in_w,
   input  logic                   req_in_last,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  qvr_pkg::comp_type      rsp_out_x,
   input  qvr_pkg::comp_type      rsp_out_y,
   input  qvr_pkg::comp_type      rsp_out_z,
   input  qvr_pkg::comp_type      rsp_out_w,
   input  logic                   rsp_out_last,
   input  logic                   csr_wr_en,
   input  qvr_pkg::csr_index_type csr_index,
   input  qvr_pkg::comp_type      csr_wdata,
   output int                     mismatches,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import qvr_pkg::*;

   // Wide enough that no product or four-term sum ever wraps.
   typedef logic signed [127:0] acc_type;
   typedef struct packed {
      acc_type x;
      acc_type y;
      acc_type z;
      acc_type w;
   } quat_acc_type;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
      comp_type w;
      logic     last;
   } rotated_type;

   comp_type    rot_reg [4];
   comp_type    inv_reg [4];
   rotated_type rotated_q [$];
   int          err_cnt = 0;

   // Drop QUAT_FRAC_BITS fraction bits, rounding toward zero.
   function automatic acc_type trunc_q(input acc_type v);
      acc_type mag;
      if (v < 0) begin
         mag = -v;
         return -(mag >>> QUAT_FRAC_BITS);
      end
      return v >>> QUAT_FRAC_BITS;
   endfunction

   function automatic comp_type sat32(input acc_type v);
      if (v > acc_type'(COMP_MAX))
         return COMP_MAX;
      if (v < acc_type'(COMP_MIN))
         return COMP_MIN;
      return comp_type'(v);
   endfunction

   function automatic quat_acc_type hamilton(input quat_acc_type a,
                                             input quat_acc_type b);
      quat_acc_type p;
      p.x = trunc_q(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y);
      p.y = trunc_q(a.w * b.y + a.y * b.w + a.z * b.x - a.x * b.z);
      p.z = trunc_q(a.w * b.z + a.z * b.w + a.x * b.y - a.y * b.x);
      p.w = trunc_q(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z);
      return p;
   endfunction

   // rot * v * inv; the intermediate stays within 36 bits, so only the
   // final components need clamping.
   function automatic rotated_type rotate_vertex(input comp_type x, input comp_type y,
                                                 input comp_type z, input comp_type w,
                                                 input logic last);
      quat_acc_type rq, vq, iq, mid, fin;
      rotated_type  r;
      rq.x = rot_reg[QX];
      rq.y = rot_reg[QY];
      rq.z = rot_reg[QZ];
      rq.w = rot_reg[QW];
      iq.x = inv_reg[QX];
      iq.y = inv_reg[QY];
      iq.z = inv_reg[QZ];
      iq.w = inv_reg[QW];
      vq.x = x;
      vq.y = y;
      vq.z = z;
      vq.w = w;
      mid = hamilton(rq, vq);
      fin = hamilton(mid, iq);
      r.x = sat32(fin.x);
      r.y = sat32(fin.y);
      r.z = sat32(fin.z);
      r.w = sat32(fin.w);
      r.last = last;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: field %s expected %h got %h", $time, name, want, got);
         err_cnt++;
      end
   endtask

   always @(posedge clock) begin
      rotated_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            rot_reg[i] = '0;
            inv_reg[i] = '0;
         end
         rot_reg[QW] = QUAT_ONE;
         inv_reg[QW] = QUAT_ONE;
         rotated_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index < CSR_INV_X)
               rot_reg[csr_index[1:0]] = csr_wdata;
            else
               inv_reg[csr_index[1:0]] = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (rotated_q.size() == 0) begin
               $display("%0t: response with nothing outstanding: %h %h %h %h %b",
                        $time, rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w,
                        rsp_out_last);
               err_cnt++;
            end else begin
               want = rotated_q.pop_front();
               check_field("x", want.x, rsp_out_x);
               check_field("y", want.y, rsp_out_y);
               check_field("z", want.z, rsp_out_z);
               check_field("w", want.w, rsp_out_w);
               check_field("last", 32'(want.last), 32'(rsp_out_last));
            end
         end
         if (req_valid && req_ready)
            rotated_q.push_back(rotate_vertex(req_in_x, req_in_y, req_in_z,
                                              req_in_w, req_in_last));
      end
      pending    <= rotated_q.size();
      mismatches <= err_cnt;
   end

endmodule

FILE: tb/sv/tb_quaternion_vertex_rotate.sv
// ---------------------------------------------------------------------------
// tb_quaternion_vertex_rotate
// Stimulus and verdict for the quaternion vertex rotation block.
// ---------------------------------------------------------------------------
// Vertex requests are streamed under a series of register settings: the
// reset identity, all-max and all-min quaternions (results can saturate), a
// quarter turn about z, and random full-range and bounded conjugate pairs. Both
// channels stall at random, with one calm phase. The checker beside the
// block predicts every response and counts failures.
// ---------------------------------------------------------------------------
module tb_quaternion_vertex_rotate;
   timeunit 1ns;
   timeprecision 1ps;
   import qvr_pkg::*;

   localparam int       PHASE_ITEMS = 205;
   localparam int       STALL_LIMIT = 5000;   // cycles with no handshake at all
   // cos(45 deg) in Q2.30
   localparam comp_type C45 = 32'sd759250125;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   comp_type      req_in_x, req_in_y, req_in_z, req_in_w;
   logic          req_in_last;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   comp_type      rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic          rsp_out_last;
   logic          csr_wr_en;
   csr_index_type csr_index;
   comp_type      csr_wdata;

   int mismatches;
   int pending;
   int idle_cycles = 0;
   bit calm = 1'b0;      // no idling on either side while set

   quaternion_vertex_rotate dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_x     (req_in_x),
      .req_in_y     (req_in_y),
      .req_in_z     (req_in_z),
      .req_in_w     (req_in_w),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_w    (rsp_out_w),
      .rsp_out_last (rsp_out_last),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   qvr_rotate_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_x     (req_in_x),
      .req_in_y     (req_in_y),
      .req_in_z     (req_in_z),
      .req_in_w     (req_in_w),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_w    (rsp_out_w),
      .rsp_out_last (rsp_out_last),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .pending      (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: holds off at random about 15 percent of the time, never while calm.
   always @(posedge clock)
      rsp_ready <= calm || ($urandom_range(0, 99) >= 15);

   // Watchdog: any accepted request or response restarts the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("quaternion_vertex_rotate: mismatch");
      $finish;
   end

   // Present one request and hold it until accepted. Valid stays high into
   // the next request unless a random gap follows.
   task automatic send_vertex(input comp_type x, input comp_type y, input comp_type z,
                              input comp_type w, input logic last);
      req_valid   <= 1'b1;
      req_in_x    <= x;
      req_in_y    <= y;
      req_in_z    <= z;
      req_in_w    <= w;
      req_in_last <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Stop sending and let the pipeline empty. pending is a registered copy of
   // the checker's queue size, so the task lets it update before polling it.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input comp_type val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Load both quaternions back to back, only with the pipeline empty.
   task automatic load_quats(input comp_type rx, input comp_type ry, input comp_type rz,
                             input comp_type rw, input comp_type ix, input comp_type iy,
                             input comp_type iz, input comp_type iw);
      drain();
      write_reg(CSR_ROT_X, rx);
      write_reg(CSR_ROT_Y, ry);
      write_reg(CSR_ROT_Z, rz);
      write_reg(CSR_ROT_W, rw);
      write_reg(CSR_INV_X, ix);
      write_reg(CSR_INV_Y, iy);
      write_reg(CSR_INV_Z, iz);
      write_reg(CSR_INV_W, iw);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly full-range words, plus small magnitudes, extremes and -1/0/1.
   function automatic comp_type rand_comp();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return comp_type'($urandom);
         5, 6, 7:       return comp_type'($urandom) >>> $urandom_range(8, 20);
         8:             return $urandom_range(0, 1) ? COMP_MAX : COMP_MIN;
         default:       return comp_type'($urandom_range(0, 2)) - 1;
      endcase
   endfunction

   // Random bounded quaternion (each component under 0.5) paired with its conjugate.
   task automatic load_unit_pair;
      comp_type qx, qy, qz, qw;
      qx = comp_type'($urandom) >>> 2;
      qy = comp_type'($urandom) >>> 2;
      qz = comp_type'($urandom) >>> 2;
      qw = comp_type'($urandom) >>> 2;
      load_quats(qx, qy, qz, qw, -qx, -qy, -qz, qw);
   endtask

   // Field extremes, sign patterns and a unit axis; last toggles.
   task automatic run_directed;
      send_vertex('0, '0, '0, '0, 1'b0);
      send_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 1'b1);
      send_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 1'b0);
      send_vertex(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, 1'b1);
      send_vertex(32'sh0001_0000, '0, '0, '0, 1'b0);
      send_vertex('0, '0, '0, 32'sh0001_0000, 1'b1);
      send_vertex(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0);
      send_vertex(-32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b1);
      send_vertex(32'sd1, 32'sd1, 32'sd1, 32'sd1, 1'b0);
   endtask

   task automatic run_random(input int count, input bit pause_midway);
      for (int i = 0; i < count; i++) begin
         // hold back the sender until the pipeline has fully emptied
         if (pause_midway && i == count / 2)
            drain();
         send_vertex(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                     $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_in_x    <= '0;
      req_in_y    <= '0;
      req_in_z    <= '0;
      req_in_w    <= '0;
      req_in_last <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_index   <= CSR_ROT_X;
      csr_wdata   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // identity after reset: vertices come back truncated but unchanged
      run_directed();

      // all-max rotation against all-min inverse: results can saturate
      load_quats(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
                 COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
      run_directed();

      // the other extreme, random vertices, with a full drain midway
      load_quats(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                 COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
      run_random(PHASE_ITEMS, 1'b1);

      // quarter turn about z
      load_quats('0, '0, C45, C45, '0, '0, -C45, C45);
      run_random(PHASE_ITEMS, 1'b0);

      // arbitrary register contents, no unit or consistency constraint
      load_quats(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_comp(), rand_comp(), rand_comp(), rand_comp());
      run_random(PHASE_ITEMS, 1'b0);

      // back-to-back stretch: neither side idles
      load_unit_pair();
      calm = 1'b1;
      run_random(PHASE_ITEMS, 1'b0);
      calm = 1'b0;

      load_quats(comp_type'($urandom), comp_type'($urandom), comp_type'($urandom),
                 comp_type'($urandom), comp_type'($urandom), comp_type'($urandom),
                 comp_type'($urandom), comp_type'($urandom));
      run_random(PHASE_ITEMS, 1'b0);

      load_unit_pair();
      run_random(PHASE_ITEMS, 1'b0);

      // wait for the last responses, then keep running to catch strays
      drain();
      repeat (20) @(posedge clock);

      if (mismatches == 0)
         $display("quaternion_vertex_rotate: match");
      else
         $display("quaternion_vertex_rotate: mismatch");
      $finish;
   end

endmodule

FILE: quaternion_vertex_rotate.f
rtl/qvr_pkg.sv
rtl/qvr_rot_mul.sv
rtl/qvr_inv_mul.sv
rtl/quaternion_vertex_rotate.sv
tb/sv/qvr_rotate_checker.sv
tb/sv/tb_quaternion_vertex_rotate.sv
